FILE: rtl/rmq_pkg.sv
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int POS_W            = 11;
    localparam int VAL_W            = 11;
    localparam int ELEM_W           = 32;
    localparam int VAL_SPACE        = 1 << VAL_W;
    localparam int MAX_ELEMENTS_DEF = 1024;

    localparam logic [VAL_W-1:0] CAP_RESET = VAL_W'(1024);

    typedef struct packed {
        logic clr_en;
        logic app_en;
        logic q_load;
        logic scan_en;
        logic scan_mark;
        logic scan_rewind;
        logic srch_init;
        logic srch_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic q_empty;
        logic scan_last;
        logic srch_found;
    } status_t;

endpackage

FILE: rtl/rmq_dp.sv
`timescale 1ns / 1ps

module rmq_dp #(
    parameter int MAX_ELEMENTS = rmq_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [rmq_pkg::VAL_W-1:0] cfg_wr_data,
    input  logic [rmq_pkg::ELEM_W-1:0] elem_value,
    input  logic [rmq_pkg::POS_W-1:0] left_pos,
    input  logic [rmq_pkg::POS_W-1:0] right_pos,
    input  rmq_pkg::cmd_t             cmd,
    output rmq_pkg::status_t          status,
    output logic [rmq_pkg::VAL_W-1:0] mex_value,
    output logic                      overflow_flag
);

    localparam int CNT_RAW = $clog2(MAX_ELEMENTS + 1);
    localparam int CNT_W   = (CNT_RAW > rmq_pkg::POS_W) ? CNT_RAW : rmq_pkg::POS_W;
    localparam int ADDR_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int VAL_W   = rmq_pkg::VAL_W;

    // element store and value presence map
    logic [VAL_W-1:0] store_mem [MAX_ELEMENTS];
    logic             pres_mem  [rmq_pkg::VAL_SPACE];

    logic [VAL_W-1:0] cap_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] pos_reg;
    logic [VAL_W:0]   srch_addr_reg;
    logic             srch_vld_reg;
    logic             rd_vld_reg;
    logic [VAL_W-1:0] clr_addr_reg;

    logic [CNT_W-1:0] left_reg;
    logic [CNT_W-1:0] right_reg;
    logic [VAL_W-1:0] elem_q_reg;
    logic             rd_mark_reg;
    logic             pres_q_reg;
    logic [VAL_W-1:0] chk_reg;
    logic [VAL_W-1:0] res_mex_reg;
    logic             res_ovf_reg;
    logic [VAL_W-1:0] out_mex_reg;
    logic             out_ovf_reg;

    logic [CNT_W-1:0] left_c;
    logic [CNT_W-1:0] right_ext;
    logic [CNT_W-1:0] right_c;
    logic             full;
    logic [VAL_W-1:0] app_val;
    logic [CNT_W-1:0] pos_m1;
    logic [VAL_W-1:0] elem_clamped;
    logic             pres_we;
    logic [VAL_W-1:0] pres_wa;
    logic             pres_wd;
    logic             found;

    always_comb
    begin
        left_c    = (left_pos == '0) ? CNT_W'(1) : CNT_W'(left_pos);
        right_ext = CNT_W'(right_pos);
        right_c   = (right_ext > cnt_reg) ? cnt_reg : right_ext;
        full      = (cnt_reg >= CNT_W'(MAX_ELEMENTS));
        app_val   = (elem_value > rmq_pkg::ELEM_W'(cap_reg)) ? cap_reg
                                                             : elem_value[VAL_W-1:0];
        pos_m1    = pos_reg - CNT_W'(1);
        elem_clamped = (elem_q_reg > cap_reg) ? cap_reg : elem_q_reg;
        found     = srch_vld_reg && ((chk_reg == cap_reg) || !pres_q_reg);

        pres_we = cmd.clr_en || rd_vld_reg;
        pres_wa = cmd.clr_en ? clr_addr_reg : elem_clamped;
        pres_wd = cmd.clr_en ? 1'b0 : rd_mark_reg;

        status.clr_last   = &clr_addr_reg;
        status.q_empty    = (left_c > right_c);
        status.scan_last  = (pos_reg == right_reg);
        status.srch_found = found;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= rmq_pkg::CAP_RESET;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            srch_addr_reg <= '0;
            srch_vld_reg  <= 1'b0;
            rd_vld_reg    <= 1'b0;
            clr_addr_reg  <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (cmd.app_en && !full)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (cmd.q_load || cmd.scan_rewind)
                pos_reg <= cmd.q_load ? left_c : left_reg;
            else if (cmd.scan_en)
                pos_reg <= pos_reg + CNT_W'(1);
            if (cmd.srch_init)
                srch_addr_reg <= '0;
            else if (cmd.srch_en)
                srch_addr_reg <= srch_addr_reg + (VAL_W+1)'(1);
            srch_vld_reg <= cmd.srch_en;
            rd_vld_reg   <= cmd.scan_en;
            if (cmd.clr_en)
                clr_addr_reg <= clr_addr_reg + VAL_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.app_en && !full)
            store_mem[cnt_reg[ADDR_W-1:0]] <= app_val;
        if (cmd.scan_en)
            elem_q_reg <= store_mem[pos_m1[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (pres_we)
            pres_mem[pres_wa] <= pres_wd;
        if (cmd.srch_en)
            pres_q_reg <= pres_mem[srch_addr_reg[VAL_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        rd_mark_reg <= cmd.scan_mark;
        chk_reg     <= srch_addr_reg[VAL_W-1:0];
        if (cmd.q_load)
        begin
            left_reg  <= left_c;
            right_reg <= right_c;
        end
        if (cmd.app_en)
        begin
            res_mex_reg <= '0;
            res_ovf_reg <= full;
        end
        else if (cmd.q_load)
        begin
            res_mex_reg <= '0;
            res_ovf_reg <= 1'b0;
        end
        else if (cmd.srch_en && found)
            res_mex_reg <= chk_reg;
        if (cmd.out_load)
        begin
            out_mex_reg <= res_mex_reg;
            out_ovf_reg <= res_ovf_reg;
        end
    end

    assign mex_value     = out_mex_reg;
    assign overflow_flag = out_ovf_reg;

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clr_en && rd_vld_reg))
        else $error("presence map clear collides with scan write");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_en |-> (pos_reg != '0) && (pos_reg <= cnt_reg))
        else $error("scan position outside loaded elements");

    a_chk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.srch_en && srch_vld_reg) |-> (chk_reg <= cap_reg))
        else $error("mex search ran past the cap");

endmodule

FILE: rtl/rmq_ctrl.sv
`timescale 1ns / 1ps

module rmq_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             req_type,
    output logic             out_valid,
    input  logic             out_ready,
    input  rmq_pkg::status_t status,
    output rmq_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MARK,
        ST_MDRAIN,
        ST_SEARCH,
        ST_UNMARK,
        ST_UDRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        slot_free      = !out_valid_reg || out_ready;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!req_type)
                    begin
                        cmd.app_en = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        cmd.q_load = 1'b1;
                        state_next = status.q_empty ? ST_FINISH : ST_MARK;
                    end
                end
            end
            ST_MARK:
            begin
                cmd.scan_en   = 1'b1;
                cmd.scan_mark = 1'b1;
                if (status.scan_last)
                    state_next = ST_MDRAIN;
            end
            ST_MDRAIN:
            begin
                cmd.srch_init   = 1'b1;
                cmd.scan_rewind = 1'b1;
                state_next      = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                cmd.srch_en = 1'b1;
                if (status.srch_found)
                    state_next = ST_UNMARK;
            end
            ST_UNMARK:
            begin
                cmd.scan_en = 1'b1;
                if (status.scan_last)
                    state_next = ST_UDRAIN;
            end
            ST_UDRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    a_rise_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
        else $error("result raised outside finish");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten before transaction");

endmodule

FILE: rtl/range_mex_query.sv
`timescale 1ns / 1ps

// Range mex engine. An append transaction (req_type 0) stores elem_value, clamped to
// value_cap, at the next position; overflow_flag marks an append dropped on a full
// store. A query transaction (req_type 1) returns the smallest value absent from
// positions left_pos..right_pos, or value_cap if all of 0..value_cap-1 are present
// (right clamped to the loaded count, left 0 read as 1, empty range answers 0). In a
// query the range is read once from the single-port element memory to set bits in a
// value presence map, the map is then searched one value per cycle, and the range is
// read again to clear the bits it set. An empty-range query skips these steps. After
// reset all 2048 presence-map entries are cleared, during which in_ready stays low.
// The next transaction is taken while a finished result still waits on the output
// register.
module range_mex_query #(
    parameter int MAX_ELEMENTS = rmq_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [rmq_pkg::VAL_W-1:0]  cfg_wr_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic [rmq_pkg::ELEM_W-1:0] elem_value,
    input  logic [rmq_pkg::POS_W-1:0]  left_pos,
    input  logic [rmq_pkg::POS_W-1:0]  right_pos,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [rmq_pkg::VAL_W-1:0]  mex_value,
    output logic                       overflow_flag
);

    rmq_pkg::cmd_t    cmd;
    rmq_pkg::status_t status;

    rmq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rmq_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .elem_value    (elem_value),
        .left_pos      (left_pos),
        .right_pos     (right_pos),
        .cmd           (cmd),
        .status        (status),
        .mex_value     (mex_value),
        .overflow_flag (overflow_flag)
    );

endmodule
